### rtl/core/sorted_priority_queue_core_macros.svh
// Assertion macros for the sorted priority queue core.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Condition holds at every edge outside reset.
`define SPQ_ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/spq_pkg.sv
// Package for the sorted priority queue core: word types, cell types, codes.
// No dependencies; used by spq_cell and sorted_priority_queue_core.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int CAPACITY  = 16;
   localparam int ELEM_BITS = 32;
   localparam int PRIO_BITS = 16;
   localparam int CNT_BITS  = 5;

   localparam logic [CNT_BITS-1:0] CAP_COUNT = CNT_BITS'(CAPACITY);

   // request kinds
   localparam logic [1:0] KIND_ENQ     = 2'd0;
   localparam logic [1:0] KIND_DEQ     = 2'd1;
   localparam logic [1:0] KIND_INSPECT = 2'd2;

   // response status
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]           kind;
      logic [ELEM_BITS-1:0] elem_value;
      logic [PRIO_BITS-1:0] prio_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ELEM_BITS-1:0] head_elem;
      logic [PRIO_BITS-1:0] head_prio;
      logic [CNT_BITS-1:0]  entry_count;
      logic                 is_empty;
      logic                 is_full;
   } rsp_word_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_ENQ,
      OP_DEQ
   } cell_op_type;

   // broadcast to every cell
   typedef struct packed {
      cell_op_type          op;
      logic [ELEM_BITS-1:0] elem;
      logic [PRIO_BITS-1:0] prio;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 used;
      logic [PRIO_BITS-1:0] prio;
      logic [ELEM_BITS-1:0] elem;
   } slot_type;

   localparam slot_type SLOT_EMPTY = '{used: 1'b0, prio: '0, elem: '0};

endpackage

### rtl/core/spq_cell.sv
// One slot of the sorted queue: holds an entry, shifts with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::slot_type     left_slot,
   input  spq_pkg::slot_type     right_slot,
   input  logic                  left_keep,
   output logic                  keep,
   output spq_pkg::slot_type     slot
);

   logic                          used_ff, used_in;
   logic [spq_pkg::PRIO_BITS-1:0] prio_ff, prio_in;
   logic [spq_pkg::ELEM_BITS-1:0] elem_ff, elem_in;

   // entry stays put on enqueue when it ranks ahead of or ties the new one
   assign keep = used_ff && (prio_ff <= ctrl.prio);

   always_comb begin
      used_in = used_ff;
      prio_in = prio_ff;
      elem_in = elem_ff;
      case (ctrl.op)
         spq_pkg::OP_ENQ: begin
            if (!keep) begin
               if (left_keep) begin
                  used_in = 1'b1;
                  prio_in = ctrl.prio;
                  elem_in = ctrl.elem;
               end else begin
                  used_in = left_slot.used;
                  prio_in = left_slot.prio;
                  elem_in = left_slot.elem;
               end
            end
         end
         spq_pkg::OP_DEQ: begin
            used_in = right_slot.used;
            prio_in = right_slot.prio;
            elem_in = right_slot.elem;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      elem_ff <= elem_in;
   end

   assign slot = '{used: used_ff, prio: prio_ff, elem: elem_ff};

endmodule

### rtl/core/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: row of spq_cell slots, count, response register.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_core_macros.svh.
//
//   channel | ports                      | direction
//   req     | req_valid req_ready req_data | in
//   rsp     | rsp_valid rsp_ready rsp_data | out
//
// One word per cycle: every cell compares and shifts in the cycle the word is taken,
// and the response shows the new head on the next cycle.
// A new word is taken whenever the response register is empty or being drained.
// Reset clears all slot valid bits and the count; no clearing pass is needed.
// A stalled response holds the state, so the next word waits on rsp_ready.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spq_pkg::rsp_word_type rsp_data
);

   spq_pkg::slot_type      slot_vec [spq_pkg::CAPACITY];
   logic [spq_pkg::CAPACITY-1:0] keep_vec;
   logic [spq_pkg::CAPACITY-1:0] used_vec;
   spq_pkg::cell_ctrl_type ctrl;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   status_ff, status_in;
   logic [spq_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic                         req_fire;
   logic                         full;
   logic                         empty;
   logic [spq_pkg::CNT_BITS-1:0] used_count;
   logic                         head_ordered;
   logic                         enq_taken;

   assign full      = (count_ff == spq_pkg::CAP_COUNT);
   assign empty     = (count_ff == '0);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      ctrl.op   = spq_pkg::OP_HOLD;
      ctrl.elem = req_data.elem_value;
      ctrl.prio = req_data.prio_value;
      status_in = status_ff;
      count_in  = count_ff;
      if (req_fire) begin
         status_in = spq_pkg::STATUS_OK;
         if (req_data.kind == spq_pkg::KIND_ENQ) begin
            if (full) begin
               status_in = spq_pkg::STATUS_FULL;
            end else begin
               ctrl.op  = spq_pkg::OP_ENQ;
               count_in = count_ff + 1'b1;
            end
         end else if (req_data.kind == spq_pkg::KIND_DEQ) begin
            if (empty) begin
               status_in = spq_pkg::STATUS_EMPTY;
            end else begin
               ctrl.op  = spq_pkg::OP_DEQ;
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   genvar gi;
   generate
      for (gi = 0; gi < spq_pkg::CAPACITY; gi++) begin : g_cell
         spq_pkg::slot_type left_slot;
         spq_pkg::slot_type right_slot;
         logic              left_keep;

         if (gi == 0) begin : g_first
            assign left_slot = spq_pkg::SLOT_EMPTY;
            assign left_keep = 1'b1;
         end else begin : g_inner
            assign left_slot = slot_vec[gi-1];
            assign left_keep = keep_vec[gi-1];
         end

         if (gi == spq_pkg::CAPACITY - 1) begin : g_last
            assign right_slot = spq_pkg::SLOT_EMPTY;
         end else begin : g_mid
            assign right_slot = slot_vec[gi+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .left_slot  (left_slot),
            .right_slot (right_slot),
            .left_keep  (left_keep),
            .keep       (keep_vec[gi]),
            .slot       (slot_vec[gi])
         );

         assign used_vec[gi] = slot_vec[gi].used;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // state only moves on an accepted word, so the response is stable while stalled
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_data.status      = status_ff;
      rsp_data.head_elem   = slot_vec[0].used ? slot_vec[0].elem : '0;
      rsp_data.head_prio   = slot_vec[0].used ? slot_vec[0].prio : '0;
      rsp_data.entry_count = count_ff;
      rsp_data.is_empty    = empty;
      rsp_data.is_full     = full;
   end

   assign used_count   = spq_pkg::CNT_BITS'($countones(used_vec));
   assign head_ordered = !used_vec[1] || (slot_vec[0].prio <= slot_vec[1].prio);
   assign enq_taken    = req_fire && (req_data.kind == spq_pkg::KIND_ENQ) && !full;

   `SPQ_ASSERT_HOLDS(a_count_matches_used, used_count == count_ff, "count does not match slots")
   `SPQ_ASSERT_HOLDS(a_head_sorted, head_ordered, "head out of order")
   `SPQ_ASSERT_NEXT(a_enq_grows, enq_taken, count_ff == $past(count_ff) + 1'b1, "count stuck")

endmodule
